### rtl/core/uaes_pkg.sv
// Shared types and constants of the upwind advection stencil unit.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package uaes_pkg;

  localparam int DIM_W       = 11;  // grid size registers
  localparam int COORD_W     = 10;  // cell coordinates
  localparam int ROW_W       = 21;
  localparam int COL_W       = 20;
  localparam int WEIGHT_W    = 64;
  localparam int FLOW_W      = 32;
  localparam int STEP_W      = 31;
  localparam int PROD_W      = FLOW_W + STEP_W;
  localparam int FRAC_W      = 16;
  localparam int MODE_W      = 2;
  localparam int SLOT_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_SLOTS   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_FLOW_X      = 3'd2,
    REG_FLOW_Y      = 3'd3,
    REG_STEP_X      = 3'd4,
    REG_STEP_Y      = 3'd5,
    REG_WEIGHT_MODE = 3'd6
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FULL   = 2'd0,
    MODE_X_SIGN = 2'd1,
    MODE_Y_SIGN = 2'd2
  } mode_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_CENTRE = 3'd0,
    SLOT_EAST   = 3'd1,
    SLOT_WEST   = 3'd2,
    SLOT_NORTH  = 3'd3,
    SLOT_SOUTH  = 3'd4
  } slot_t;

  // One classified cell, as it waits between front and back.
  typedef struct packed {
    logic [ROW_W-1:0] k;
    logic             x_first;
    logic             x_last;
    logic             y_first;
    logic             y_last;
  } entry_t;

  // Configuration-derived values seen by front and back.
  typedef struct packed {
    logic [DIM_W-1:0]                   w;
    logic [DIM_W-1:0]                   h;
    logic [ROW_W-1:0]                   dummy;
    logic [NUM_SLOTS-1:0][WEIGHT_W-1:0] base;
    logic [WEIGHT_W-1:0]                hx;
    logic [WEIGHT_W-1:0]                hy;
  } cfg_view_t;

endpackage

`default_nettype wire

### rtl/core/upwind_advection_stencil_entries_unit.sv
// Top level of the upwind advection stencil unit.
// Depends on uaes_pkg, uaes_cfg, uaes_front, uaes_queue and uaes_back.
//
// Usage:
//   A cell (in_cell_x, in_cell_y) is taken on a clock edge with in_valid
//   high and in_stall low. For each cell five triplets (row, column,
//   weight) leave on the out_ channel in slot order centre, east, west,
//   north, south; out_last marks the south entry.
//   The centre entry passes through the front register, the request
//   queue and the output register. One result leaves per cycle while
//   out_stall is low and a cell is queued, set by the single result port
//   of the back end. Cells follow back to back; the front register and a
//   two-deep request queue hold up to three cells, the emitted one included.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   unit is idle; derived weights settle via the product and base registers.
//   Reset (rst_n low, synchronous) restores the register defaults (1 x 1
//   grid, zero flow, unit spacing, full upwind) and empties the pipeline.
//   When out_stall is high the output register holds its triplet; the
//   queue fills and in_stall rises once it and the front register are full.
`default_nettype none

module upwind_advection_stencil_entries_unit #(
  parameter int MAX_DIM = uaes_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [uaes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [uaes_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [uaes_pkg::COORD_W-1:0]        in_cell_x,
  input  wire logic [uaes_pkg::COORD_W-1:0]        in_cell_y,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [uaes_pkg::SLOT_W-1:0]         out_slot,
  output      logic [uaes_pkg::ROW_W-1:0]          out_matrix_row,
  output      logic [uaes_pkg::COL_W-1:0]          out_matrix_col,
  output      logic signed [uaes_pkg::WEIGHT_W-1:0] out_weight,
  output      logic                                out_last
);

  uaes_pkg::cfg_view_t view;
  uaes_pkg::entry_t    push_entry, head;
  logic                push, pop, q_empty, q_full;

  uaes_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  uaes_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cell_x  (in_cell_x),
    .in_cell_y  (in_cell_y),
    .w          (view.w),
    .h          (view.h),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  uaes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  uaes_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .view           (view),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot       (out_slot),
    .out_matrix_row (out_matrix_row),
    .out_matrix_col (out_matrix_col),
    .out_weight     (out_weight),
    .out_last       (out_last)
  );

  // last flag goes with the south slot only
  a_last_is_south: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_slot == uaes_pkg::SLOT_SOUTH)))
    else $error("out_last does not match south slot");

  // a cell's five entries come without gaps
  a_no_gap_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("gap inside a cell's entries");

  // slots advance in order and restart at centre after the last
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=>
      (!out_valid || out_slot == ($past(out_last) ? uaes_pkg::SLOT_CENTRE
                                                  : $past(out_slot) + 3'd1)))
    else $error("slot order broken");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request queue overflow");

endmodule

`default_nettype wire

### rtl/core/uaes_cfg.sv
// Configuration registers and the weights derived from them.
// Depends on uaes_pkg.
`default_nettype none

module uaes_cfg #(
  parameter int MAX_DIM = uaes_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [uaes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uaes_pkg::CFG_DATA_W-1:0]  cfg_data,
  output uaes_pkg::cfg_view_t                   view
);

  localparam int DW = uaes_pkg::DIM_W;
  localparam int WW = uaes_pkg::WEIGHT_W;
  localparam int PW = uaes_pkg::PROD_W;
  localparam int FW = uaes_pkg::FRAC_W;

  logic [DW-1:0]                  grid_width_r, grid_height_r;
  logic [uaes_pkg::FLOW_W-1:0]    flow_x_r, flow_y_r;
  logic [uaes_pkg::STEP_W-1:0]    step_x_r, step_y_r;
  logic [uaes_pkg::MODE_W-1:0]    weight_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DW'(1);
      grid_height_r <= DW'(1);
      flow_x_r      <= '0;
      flow_y_r      <= '0;
      step_x_r      <= uaes_pkg::STEP_RESET;
      step_y_r      <= uaes_pkg::STEP_RESET;
      weight_mode_r <= '0;
    end else if (cfg_we) begin
      unique case (uaes_pkg::cfg_reg_t'(cfg_index))
        uaes_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[DW-1:0];
        uaes_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[DW-1:0];
        uaes_pkg::REG_FLOW_X:      flow_x_r      <= cfg_data[uaes_pkg::FLOW_W-1:0];
        uaes_pkg::REG_FLOW_Y:      flow_y_r      <= cfg_data[uaes_pkg::FLOW_W-1:0];
        uaes_pkg::REG_STEP_X:      step_x_r      <= cfg_data[uaes_pkg::STEP_W-1:0];
        uaes_pkg::REG_STEP_Y:      step_y_r      <= cfg_data[uaes_pkg::STEP_W-1:0];
        uaes_pkg::REG_WEIGHT_MODE: weight_mode_r <= cfg_data[uaes_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // grid size clamped to 1..MAX_DIM
  logic [DW-1:0] w_cl, h_cl;
  always_comb begin
    w_cl = grid_width_r;
    h_cl = grid_height_r;
    if (grid_width_r == '0) w_cl = DW'(1);
    else if (32'(grid_width_r) > 32'(MAX_DIM)) w_cl = DW'(MAX_DIM);
    if (grid_height_r == '0) h_cl = DW'(1);
    else if (32'(grid_height_r) > 32'(MAX_DIM)) h_cl = DW'(MAX_DIM);
  end

  // first stage: flux products and dummy row
  logic [uaes_pkg::FLOW_W-1:0] ax, ay;
  logic [PW-1:0]               prod_x_r, prod_y_r;
  logic [uaes_pkg::ROW_W-1:0]  dummy_r;

  assign ax = flow_x_r[uaes_pkg::FLOW_W-1] ? (~flow_x_r + 1'b1) : flow_x_r;
  assign ay = flow_y_r[uaes_pkg::FLOW_W-1] ? (~flow_y_r + 1'b1) : flow_y_r;

  always_ff @(posedge clk) begin
    prod_x_r <= PW'(ax) * PW'(step_y_r);
    prod_y_r <= PW'(ay) * PW'(step_x_r);
    dummy_r  <= uaes_pkg::ROW_W'((2 * DW)'(w_cl) * (2 * DW)'(h_cl));
  end

  // second stage: per-slot base weights for the selected mode
  logic [WW-1:0] px, py, hx, hy, sx, sy, neg_sx, neg_sy, neg_px, neg_py;
  logic          x_pos, x_neg, y_pos, y_neg;
  logic [uaes_pkg::NUM_SLOTS-1:0][WW-1:0] base_nxt, base_r;
  logic [WW-1:0] hx_r, hy_r;

  assign px     = WW'(prod_x_r[PW-1:FW]);
  assign py     = WW'(prod_y_r[PW-1:FW]);
  assign hx     = WW'(prod_x_r[PW-1:FW+1]);
  assign hy     = WW'(prod_y_r[PW-1:FW+1]);
  assign sx     = WW'(step_x_r);
  assign sy     = WW'(step_y_r);
  assign neg_sx = ~sx + 1'b1;
  assign neg_sy = ~sy + 1'b1;
  assign neg_px = ~px + 1'b1;
  assign neg_py = ~py + 1'b1;
  assign x_neg  = flow_x_r[uaes_pkg::FLOW_W-1];
  assign y_neg  = flow_y_r[uaes_pkg::FLOW_W-1];
  assign x_pos  = !x_neg && (flow_x_r != '0);
  assign y_pos  = !y_neg && (flow_y_r != '0);

  always_comb begin
    base_nxt = '0;
    unique case (uaes_pkg::mode_t'(weight_mode_r))
      uaes_pkg::MODE_X_SIGN: begin
        if (x_pos) begin
          base_nxt[uaes_pkg::SLOT_CENTRE] = sy;
          base_nxt[uaes_pkg::SLOT_WEST]   = neg_sy;
        end else if (x_neg) begin
          base_nxt[uaes_pkg::SLOT_CENTRE] = neg_sy;
          base_nxt[uaes_pkg::SLOT_EAST]   = sy;
        end else begin
          // zero flow: halves floor towards minus infinity
          base_nxt[uaes_pkg::SLOT_EAST]   = {1'b0, sy[WW-1:1]};
          base_nxt[uaes_pkg::SLOT_WEST]   = {neg_sy[WW-1], neg_sy[WW-1:1]};
        end
      end
      uaes_pkg::MODE_Y_SIGN: begin
        if (y_pos) begin
          base_nxt[uaes_pkg::SLOT_CENTRE] = sx;
          base_nxt[uaes_pkg::SLOT_SOUTH]  = neg_sx;
        end else if (y_neg) begin
          base_nxt[uaes_pkg::SLOT_CENTRE] = neg_sx;
          base_nxt[uaes_pkg::SLOT_NORTH]  = sx;
        end else begin
          base_nxt[uaes_pkg::SLOT_NORTH]  = {1'b0, sx[WW-1:1]};
          base_nxt[uaes_pkg::SLOT_SOUTH]  = {neg_sx[WW-1], neg_sx[WW-1:1]};
        end
      end
      default: begin
        base_nxt[uaes_pkg::SLOT_CENTRE] = px + py;
        base_nxt[uaes_pkg::SLOT_EAST]   = x_neg ? neg_px : '0;
        base_nxt[uaes_pkg::SLOT_WEST]   = x_pos ? neg_px : '0;
        base_nxt[uaes_pkg::SLOT_NORTH]  = y_neg ? neg_py : '0;
        base_nxt[uaes_pkg::SLOT_SOUTH]  = y_pos ? neg_py : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    hx_r   <= hx;
    hy_r   <= hy;
  end

  assign view.w     = w_cl;
  assign view.h     = h_cl;
  assign view.dummy = dummy_r;
  assign view.base  = base_r;
  assign view.hx    = hx_r;
  assign view.hy    = hy_r;

endmodule

`default_nettype wire

### rtl/core/uaes_front.sv
// Front end: takes cell requests, clamps them and classifies boundaries.
// Depends on uaes_pkg.
`default_nettype none

module uaes_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [uaes_pkg::COORD_W-1:0]   in_cell_x,
  input  wire logic [uaes_pkg::COORD_W-1:0]   in_cell_y,
  input  wire logic [uaes_pkg::DIM_W-1:0]     w,
  input  wire logic [uaes_pkg::DIM_W-1:0]     h,
  input  wire logic                           q_full,
  output      logic                           push,
  output      uaes_pkg::entry_t               push_entry
);

  localparam int CW = uaes_pkg::COORD_W;
  localparam int DW = uaes_pkg::DIM_W;
  localparam int RW = uaes_pkg::ROW_W;

  logic [DW-1:0] wm1, hm1;
  logic [CW-1:0] x_cl, y_cl;
  logic          accept;
  logic          valid_r, valid_nxt;
  uaes_pkg::entry_t entry_r, entry_nxt;

  assign wm1 = w - 1'b1;
  assign hm1 = h - 1'b1;
  assign x_cl = (DW'(in_cell_x) > wm1) ? wm1[CW-1:0] : in_cell_x;
  assign y_cl = (DW'(in_cell_y) > hm1) ? hm1[CW-1:0] : in_cell_y;

  always_comb begin
    entry_nxt.k       = RW'(RW'(y_cl) * RW'(w)) + RW'(x_cl);
    entry_nxt.x_first = (x_cl == '0);
    entry_nxt.x_last  = (DW'(x_cl) == wm1);
    entry_nxt.y_first = (y_cl == '0);
    entry_nxt.y_last  = (DW'(y_cl) == hm1);
  end

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = valid_r && !q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (accept)    valid_nxt = 1'b1;
    else if (push) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign push_entry = entry_r;

endmodule

`default_nettype wire

### rtl/core/uaes_queue.sv
// Short request queue between front and back ends.
// Depends on uaes_pkg.
`default_nettype none

module uaes_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire uaes_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output      uaes_pkg::entry_t  head,
  output      logic              empty,
  output      logic              full
);

  localparam int DEPTH = uaes_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uaes_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head = mem[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/core/uaes_back.sv
// Back end: walks the five stencil slots of the head request into a
// registered output. Depends on uaes_pkg.
`default_nettype none

module uaes_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire uaes_pkg::entry_t                  head,
  input  wire logic                              q_empty,
  output      logic                              pop,
  input  wire uaes_pkg::cfg_view_t               view,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [uaes_pkg::SLOT_W-1:0]       out_slot,
  output      logic [uaes_pkg::ROW_W-1:0]        out_matrix_row,
  output      logic [uaes_pkg::COL_W-1:0]        out_matrix_col,
  output      logic signed [uaes_pkg::WEIGHT_W-1:0] out_weight,
  output      logic                              out_last
);

  localparam int RW = uaes_pkg::ROW_W;
  localparam int CL = uaes_pkg::COL_W;
  localparam int WW = uaes_pkg::WEIGHT_W;

  uaes_pkg::slot_t slot_r, slot_nxt;
  logic            out_free, load;
  logic            out_valid_r, out_valid_nxt;

  logic [RW-1:0] row_sel, col_sel;
  logic [WW-1:0] wt_sel, dx, dy;
  logic [uaes_pkg::SLOT_W-1:0] out_slot_r;
  logic [RW-1:0] row_r;
  logic [CL-1:0] col_r;
  logic [WW-1:0] wt_r;
  logic          last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign load     = !q_empty && out_free;
  assign pop      = load && (slot_r == uaes_pkg::SLOT_SOUTH);

  // centre loses a half flux per boundary touched on each axis
  always_comb begin
    dx = '0;
    dy = '0;
    if (head.x_first && head.x_last)      dx = {view.hx[WW-2:0], 1'b0};
    else if (head.x_first || head.x_last) dx = view.hx;
    if (head.y_first && head.y_last)      dy = {view.hy[WW-2:0], 1'b0};
    else if (head.y_first || head.y_last) dy = view.hy;
  end

  always_comb begin
    row_sel  = head.k;
    col_sel  = head.k;
    wt_sel   = view.base[uaes_pkg::SLOT_CENTRE] - dx - dy;
    slot_nxt = slot_r;
    unique case (slot_r)
      uaes_pkg::SLOT_CENTRE: begin
        slot_nxt = uaes_pkg::SLOT_EAST;
      end
      uaes_pkg::SLOT_EAST: begin
        wt_sel   = view.base[uaes_pkg::SLOT_EAST];
        row_sel  = head.x_last ? view.dummy : head.k;
        col_sel  = head.x_last ? head.k : head.k + 1'b1;
        slot_nxt = uaes_pkg::SLOT_WEST;
      end
      uaes_pkg::SLOT_WEST: begin
        wt_sel   = view.base[uaes_pkg::SLOT_WEST];
        row_sel  = head.x_first ? view.dummy : head.k;
        col_sel  = head.x_first ? head.k : head.k - 1'b1;
        slot_nxt = uaes_pkg::SLOT_NORTH;
      end
      uaes_pkg::SLOT_NORTH: begin
        wt_sel   = view.base[uaes_pkg::SLOT_NORTH];
        row_sel  = head.y_last ? view.dummy : head.k;
        col_sel  = head.y_last ? head.k : head.k + RW'(view.w);
        slot_nxt = uaes_pkg::SLOT_SOUTH;
      end
      uaes_pkg::SLOT_SOUTH: begin
        wt_sel   = view.base[uaes_pkg::SLOT_SOUTH];
        row_sel  = head.y_first ? view.dummy : head.k;
        col_sel  = head.y_first ? head.k : head.k - RW'(view.w);
        slot_nxt = uaes_pkg::SLOT_CENTRE;
      end
      default: begin
        slot_nxt = uaes_pkg::SLOT_CENTRE;
      end
    endcase
    if (!load) slot_nxt = slot_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load)            out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= uaes_pkg::SLOT_CENTRE;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r <= slot_r;
      row_r      <= row_sel;
      col_r      <= col_sel[CL-1:0];
      wt_r       <= wt_sel;
      last_r     <= (slot_r == uaes_pkg::SLOT_SOUTH);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_matrix_row = row_r;
  assign out_matrix_col = col_r;
  assign out_weight     = wt_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire
